FILE: hdl/flight_phase_shutdown_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the flight phase shutdown detector
// Shared helpers for the concurrent checks at the end of the top RTL module.
// ----------------------------------------------------------------------------
`ifndef FLIGHT_PHASE_SHUTDOWN_DETECTOR_DEFINES_SVH
`define FLIGHT_PHASE_SHUTDOWN_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FPSD_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpsd check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define FPSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpsd check failed: next-cycle implication");

`endif

FILE: hdl/fpsd_pkg.sv
// ----------------------------------------------------------------------------
// Flight phase shutdown detector package
// Modes, operation and event codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package fpsd_pkg;

   typedef enum logic [2:0] {
      MODE_READY     = 3'd0,
      MODE_ARMED     = 3'd1,
      MODE_SHADOW    = 3'd2,
      MODE_ACTIVE    = 3'd3,
      MODE_UNPOWERED = 3'd4,
      MODE_END       = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      OP_EVENT  = 2'd0,
      OP_TICK   = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [2:0] EV_FORCE_START = 3'd0;
   localparam logic [2:0] EV_ARMED       = 3'd1;
   localparam logic [2:0] EV_FORCE_STOP  = 3'd2;
   localparam logic [2:0] EV_DISARMED    = 3'd3;
   localparam logic [2:0] EV_LIFTOFF     = 3'd4;
   localparam logic [2:0] EV_APOGEE      = 3'd5;
   localparam logic [2:0] EV_LANDING     = 3'd6;

   localparam logic [1:0] CSR_PRESSURE_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_APOGEE_TARGET      = 2'd1;
   localparam logic [1:0] CSR_SHUTDOWN_SAMPLES   = 2'd2;
   localparam logic [1:0] CSR_SHADOW_TIMEOUT     = 2'd3;

   localparam logic [23:0]        RESET_PRESSURE_THRESHOLD = 24'd100000;
   localparam logic signed [17:0] RESET_APOGEE_TARGET      = 18'sd3000;
   localparam logic [15:0]        RESET_SHUTDOWN_SAMPLES   = 16'd5;
   localparam logic [23:0]        RESET_SHADOW_TIMEOUT     = 24'd1000;

   typedef struct packed {
      logic [23:0]        pressure_threshold;
      logic signed [17:0] apogee_target;
      logic [15:0]        shutdown_samples;
      logic [23:0]        shadow_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      op_type             operation;
      logic [2:0]         event_code;
      logic [23:0]        chamber_pressure;
      logic signed [17:0] estimated_apogee;
   } item_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] vote_count;
      logic [23:0] shadow_timer;
   } state_type;

   typedef struct packed {
      mode_type mode;
      logic     estimator_enabled;
      logic     shutdown_flag;
   } result_type;

endpackage

FILE: hdl/fpsd_step.sv
// ----------------------------------------------------------------------------
// Flight phase shutdown detector step logic
// Next mode, counters and result flags for one item, from the current state.
// ----------------------------------------------------------------------------
module fpsd_step (
   input  fpsd_pkg::cfg_type    cfg,
   input  fpsd_pkg::state_type  state,
   input  fpsd_pkg::item_type   item,
   output fpsd_pkg::state_type  next_state,
   output fpsd_pkg::result_type result
);
   import fpsd_pkg::*;

   logic [23:0] timer_inc;
   logic [15:0] vote_inc;
   logic        live;
   logic        counted;

   assign timer_inc = (state.shadow_timer == '1) ? state.shadow_timer
                                                 : state.shadow_timer + 24'd1;
   assign vote_inc  = (state.vote_count == '1) ? state.vote_count
                                               : state.vote_count + 16'd1;
   assign live = (state.mode == MODE_ARMED) || (state.mode == MODE_SHADOW) ||
                 (state.mode == MODE_ACTIVE) || (state.mode == MODE_UNPOWERED);
   assign counted = live && (item.chamber_pressure > cfg.pressure_threshold);

   always_comb begin
      next_state               = state;
      result.estimator_enabled = 1'b0;
      result.shutdown_flag     = 1'b0;

      unique case (item.operation)
         OP_EVENT: begin
            unique case (state.mode)
               MODE_READY: begin
                  if (item.event_code == EV_FORCE_START || item.event_code == EV_ARMED) begin
                     next_state.mode = MODE_ARMED;
                  end
               end
               MODE_ARMED: begin
                  priority if (item.event_code == EV_FORCE_STOP ||
                               item.event_code == EV_DISARMED) begin
                     next_state.mode = MODE_READY;
                  end else if (item.event_code == EV_LIFTOFF) begin
                     next_state.mode         = MODE_SHADOW;
                     next_state.shadow_timer = '0;
                  end else begin
                  end
               end
               MODE_SHADOW, MODE_ACTIVE: begin
                  priority if (item.event_code == EV_FORCE_STOP) begin
                     next_state.mode = MODE_READY;
                  end else if (item.event_code == EV_APOGEE) begin
                     next_state.mode = MODE_UNPOWERED;
                  end else if (item.event_code == EV_LANDING) begin
                     next_state.mode = MODE_END;
                  end else begin
                  end
               end
               MODE_UNPOWERED: begin
                  priority if (item.event_code == EV_FORCE_STOP) begin
                     next_state.mode = MODE_READY;
                  end else if (item.event_code == EV_LANDING) begin
                     next_state.mode = MODE_END;
                  end else begin
                  end
               end
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            if (state.mode == MODE_SHADOW) begin
               next_state.shadow_timer = timer_inc;
               if (timer_inc >= cfg.shadow_timeout_ticks) begin
                  next_state.mode = MODE_ACTIVE;
               end
            end
         end
         OP_SAMPLE: begin
            if (counted) begin
               result.estimator_enabled = 1'b1;
               // armed samples feed the estimator but do not vote
               if (state.mode != MODE_ARMED) begin
                  next_state.vote_count = (item.estimated_apogee > cfg.apogee_target)
                                          ? vote_inc : 16'd0;
                  result.shutdown_flag  = (state.mode == MODE_UNPOWERED) &&
                                          (next_state.vote_count > cfg.shutdown_samples);
               end
            end
         end
         default: begin
         end
      endcase

      result.mode = next_state.mode;
   end

endmodule

FILE: hdl/flight_phase_shutdown_detector.sv
// ----------------------------------------------------------------------------
// Flight phase shutdown detector
// Mode sequencer and shutdown vote counter for an engine-shutdown estimator.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries flight events, time ticks and estimator samples; one
//   rsp_* transfer follows every req_* transfer, in order, giving the mode
//   after the item and the estimator and shutdown flags of a sample.
//   csr_* writes the four thresholds; write only while no item is in flight.
// Path: a request transfer loads the input register; the item moves on into
//   the result register, which drives rsp_valid, once that register is free.
// Throughput: one item per cycle while results are taken; the mode, vote and
//   timer update is combinational between the input and result registers.
// Reset: mode returns to ready, vote count and shadow timer clear, the
//   thresholds take their defaults and both pipeline registers empty.
// Stall: while rsp_ready is low the result holds; the input register takes
//   one more item, then req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "flight_phase_shutdown_detector_defines.svh"

module flight_phase_shutdown_detector (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [2:0]         req_event_code,
   input  logic [23:0]        req_chamber_pressure,
   input  logic signed [17:0] req_estimated_apogee,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_mode,
   output logic               rsp_estimator_enabled,
   output logic               rsp_shutdown_flag,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);
   import fpsd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_next;
   item_type   item_ff, item_in;
   result_type rsp_result_ff, step_result;
   logic       item_valid_ff, item_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       item_fire;
   logic       req_fire;

   // advance the input stage whenever the result register is free or draining
   assign item_fire = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || item_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_in.operation        = op_type'(req_operation);
      item_in.event_code       = req_event_code;
      item_in.chamber_pressure = req_chamber_pressure;
      item_in.estimated_apogee = req_estimated_apogee;

      item_valid_in = req_fire || (item_valid_ff && !item_fire);
      rsp_valid_in  = item_fire || (rsp_valid_ff && !rsp_ready);

      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PRESSURE_THRESHOLD: cfg_in.pressure_threshold   = csr_data;
            CSR_APOGEE_TARGET:      cfg_in.apogee_target        = csr_data[17:0];
            CSR_SHUTDOWN_SAMPLES:   cfg_in.shutdown_samples     = csr_data[15:0];
            CSR_SHADOW_TIMEOUT:     cfg_in.shadow_timeout_ticks = csr_data;
            default: begin
            end
         endcase
      end
   end

   fpsd_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .next_state (state_next),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressure_threshold   <= RESET_PRESSURE_THRESHOLD;
         cfg_ff.apogee_target        <= RESET_APOGEE_TARGET;
         cfg_ff.shutdown_samples     <= RESET_SHUTDOWN_SAMPLES;
         cfg_ff.shadow_timeout_ticks <= RESET_SHADOW_TIMEOUT;
         state_ff.mode               <= MODE_READY;
         state_ff.vote_count         <= '0;
         state_ff.shadow_timer       <= '0;
         item_valid_ff               <= 1'b0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (item_fire) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (item_fire) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mode              = rsp_result_ff.mode;
   assign rsp_estimator_enabled = rsp_result_ff.estimator_enabled;
   assign rsp_shutdown_flag     = rsp_result_ff.shutdown_flag;

   `FPSD_ASSERT_HOLDS(a_flag_only_unpowered, clock, reset,
                      rsp_valid_ff && rsp_result_ff.shutdown_flag,
                      rsp_result_ff.mode == MODE_UNPOWERED)
   `FPSD_ASSERT_HOLDS(a_flag_needs_enable, clock, reset,
                      rsp_valid_ff && rsp_result_ff.shutdown_flag,
                      rsp_result_ff.estimator_enabled)
   `FPSD_ASSERT_NEXT(a_state_holds_idle, clock, reset, !item_fire, $stable(state_ff))
   `FPSD_ASSERT_NEXT(a_tick_outside_shadow, clock, reset,
                     item_fire && item_ff.operation == OP_TICK &&
                     state_ff.mode != MODE_SHADOW,
                     $stable(state_ff))

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Flight phase shutdown detector testbench
// Drives flight events, ticks and estimator samples through the detector,
// predicts mode and flags per item and checks every result in order, over
// several threshold settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
   import fpsd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [2:0] EV_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = '0;
   logic [2:0]         req_event_code = '0;
   logic [23:0]        req_chamber_pressure = '0;
   logic signed [17:0] req_estimated_apogee = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_mode;
   logic               rsp_estimator_enabled;
   logic               rsp_shutdown_flag;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [23:0]        csr_data = '0;

   item_type   pending_items[$];
   result_type expected_status[$];
   item_type   cur_item;

   // predicted block state and thresholds
   cfg_type     cfg_now;
   mode_type    mode_now = MODE_READY;
   logic [15:0] votes_now = '0;
   logic [23:0] timer_now = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int cycle_count = 0;

   flight_phase_shutdown_detector i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_event_code        (req_event_code),
      .req_chamber_pressure  (req_chamber_pressure),
      .req_estimated_apogee  (req_estimated_apogee),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_mode              (rsp_mode),
      .rsp_estimator_enabled (rsp_estimator_enabled),
      .rsp_shutdown_flag     (rsp_shutdown_flag),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Step the sequencer by one item and return the status it reports.
   function automatic result_type advance_sequencer(item_type it);
      result_type r;
      r.estimator_enabled = 1'b0;
      r.shutdown_flag = 1'b0;
      case (it.operation)
         OP_EVENT: begin
            case (mode_now)
               MODE_READY: begin
                  if (it.event_code == EV_FORCE_START || it.event_code == EV_ARMED)
                     mode_now = MODE_ARMED;
               end
               MODE_ARMED: begin
                  if (it.event_code == EV_FORCE_STOP || it.event_code == EV_DISARMED) begin
                     mode_now = MODE_READY;
                  end else if (it.event_code == EV_LIFTOFF) begin
                     mode_now = MODE_SHADOW;
                     timer_now = '0;
                  end
               end
               MODE_SHADOW, MODE_ACTIVE: begin
                  if (it.event_code == EV_FORCE_STOP)
                     mode_now = MODE_READY;
                  else if (it.event_code == EV_APOGEE)
                     mode_now = MODE_UNPOWERED;
                  else if (it.event_code == EV_LANDING)
                     mode_now = MODE_END;
               end
               MODE_UNPOWERED: begin
                  if (it.event_code == EV_FORCE_STOP)
                     mode_now = MODE_READY;
                  else if (it.event_code == EV_LANDING)
                     mode_now = MODE_END;
               end
               default: ;
            endcase
         end
         OP_TICK: begin
            if (mode_now == MODE_SHADOW) begin
               if (timer_now != 24'hFFFFFF)
                  timer_now = timer_now + 1'b1;
               if (timer_now >= cfg_now.shadow_timeout_ticks)
                  mode_now = MODE_ACTIVE;
            end
         end
         OP_SAMPLE: begin
            if (mode_now != MODE_READY && mode_now != MODE_END &&
                it.chamber_pressure > cfg_now.pressure_threshold) begin
               r.estimator_enabled = 1'b1;
               if (mode_now != MODE_ARMED) begin
                  if ($signed(it.estimated_apogee) > $signed(cfg_now.apogee_target)) begin
                     if (votes_now != 16'hFFFF)
                        votes_now = votes_now + 1'b1;
                  end else begin
                     votes_now = '0;
                  end
                  if (mode_now == MODE_UNPOWERED && votes_now > cfg_now.shutdown_samples)
                     r.shutdown_flag = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.mode = mode_now;
      return r;
   endfunction

   // Request side: predict on each transfer, then present the next item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_status.push_back(advance_sequencer(cur_item));
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_item = pending_items.pop_front();
               req_operation <= cur_item.operation;
               req_event_code <= cur_item.event_code;
               req_chamber_pressure <= cur_item.chamber_pressure;
               req_estimated_apogee <= cur_item.estimated_apogee;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: check each transfer against the oldest prediction.
   always @(posedge clock) begin
      result_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: mode %0d en %0b flag %0b",
                           rsp_mode, rsp_estimator_enabled, rsp_shutdown_flag);
            end else begin
               exp_r = expected_status.pop_front();
               if (rsp_mode !== exp_r.mode ||
                   rsp_estimator_enabled !== exp_r.estimator_enabled ||
                   rsp_shutdown_flag !== exp_r.shutdown_flag) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: mode %0d/%0d en %0b/%0b flag %0b/%0b",
                              exp_r.mode, rsp_mode,
                              exp_r.estimator_enabled, rsp_estimator_enabled,
                              exp_r.shutdown_flag, rsp_shutdown_flag);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [23:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_PRESSURE_THRESHOLD: cfg_now.pressure_threshold = value;
         CSR_APOGEE_TARGET:      cfg_now.apogee_target = value[17:0];
         CSR_SHUTDOWN_SAMPLES:   cfg_now.shutdown_samples = value[15:0];
         default:                cfg_now.shadow_timeout_ticks = value;
      endcase
      @(negedge clock);
   endtask

   task automatic set_thresholds(logic [23:0] thr, logic [17:0] target,
                                 logic [15:0] votes, logic [23:0] timeout);
      write_reg(CSR_PRESSURE_THRESHOLD, thr);
      write_reg(CSR_APOGEE_TARGET, {6'b0, target});
      write_reg(CSR_SHUTDOWN_SAMPLES, {8'b0, votes});
      write_reg(CSR_SHADOW_TIMEOUT, timeout);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_items.size() > 0 || req_valid || expected_status.size() > 0);
   endtask

   task automatic push_item(op_type op, logic [2:0] code, logic [23:0] pres,
                            logic [17:0] apo);
      item_type it;
      it.operation = op;
      it.event_code = code;
      it.chamber_pressure = pres;
      it.estimated_apogee = apo;
      pending_items.push_back(it);
   endtask

   task automatic push_event(logic [2:0] code);
      push_item(OP_EVENT, code, 24'($urandom), 18'($urandom));
   endtask

   task automatic push_tick();
      push_item(OP_TICK, 3'($urandom), 24'($urandom), 18'($urandom));
   endtask

   task automatic push_sample_at(logic [23:0] pres, logic [17:0] apo);
      push_item(OP_SAMPLE, 3'($urandom), pres, apo);
   endtask

   // Pressure mostly just above the threshold, sometimes at or below it.
   function automatic logic [23:0] pick_pressure();
      int thr;
      int room;
      int unsigned sel;
      thr = int'(cfg_now.pressure_threshold);
      room = 24'hFFFFFF - thr;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return 24'($urandom);
      if (sel == 1)
         return 24'(thr);
      if (sel == 2)
         return (thr == 0) ? 24'd0 : 24'(thr - 1 - int'($urandom_range(0, thr - 1) % 5000));
      if (room == 0)
         return 24'(thr);
      return 24'(thr + 1 + int'($urandom_range(0, (room > 5000) ? 4999 : room - 1)));
   endfunction

   // Apogee mostly above target so votes build up.
   function automatic logic [17:0] pick_apogee();
      int t;
      int room;
      int low;
      int unsigned sel;
      t = int'($signed(cfg_now.apogee_target));
      room = 131071 - t;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return 18'($urandom);
      if (sel == 1)
         return 18'(t);
      if (sel == 2) begin
         low = t - 1 - int'($urandom_range(0, 50));
         return 18'((low < -131072) ? -131072 : low);
      end
      if (room == 0)
         return 18'(t);
      return 18'(t + 1 + int'($urandom_range(0, (room > 200) ? 199 : room - 1)));
   endfunction

   task automatic push_sample();
      push_sample_at(pick_pressure(), pick_apogee());
   endtask

   // Anything but landing, so that noise never locks the block in end.
   task automatic push_noise();
      logic [2:0] code;
      code = 3'($urandom_range(0, 6));
      if (code == EV_LANDING)
         code = EV_UNUSED;
      push_item(op_type'($urandom_range(0, 3)), code, 24'($urandom), 18'($urandom));
   endtask

   task automatic add_flight(bit land);
      push_event($urandom_range(0, 1) ? EV_ARMED : EV_FORCE_START);
      repeat ($urandom_range(0, 2)) push_sample();
      if ($urandom_range(0, 7) == 0) begin
         push_event($urandom_range(0, 1) ? EV_DISARMED : EV_FORCE_STOP);
         push_event(EV_ARMED);
      end
      push_event(EV_LIFTOFF);
      repeat ($urandom_range(2, 12)) begin
         case ($urandom_range(0, 3))
            0, 1:    push_tick();
            2:       push_sample();
            default: push_noise();
         endcase
      end
      if ($urandom_range(0, 5) != 0)
         push_event(EV_APOGEE);
      repeat ($urandom_range(2, 12)) begin
         if ($urandom_range(0, 9) == 0)
            push_noise();
         else
            push_sample();
      end
      push_event(land ? EV_LANDING : EV_FORCE_STOP);
   endtask

   task automatic run_flights(int count, int send_pct, int recv_pct);
      int start;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      start = pending_items.size();
      while (pending_items.size() - start < count)
         add_flight(1'b0);
      wait_idle();
   endtask

   initial begin
      cfg_now.pressure_threshold = RESET_PRESSURE_THRESHOLD;
      cfg_now.apogee_target = RESET_APOGEE_TARGET;
      cfg_now.shutdown_samples = RESET_SHUTDOWN_SAMPLES;
      cfg_now.shadow_timeout_ticks = RESET_SHADOW_TIMEOUT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk through the modes at reset thresholds
      push_item(OP_NONE, EV_FORCE_START, 24'd0, 18'sd0);
      push_sample_at(24'hFFFFFF, 18'sh1FFFF);
      push_tick();
      push_event(EV_UNUSED);
      push_event(EV_FORCE_STOP);
      push_event(EV_ARMED);
      push_sample_at(24'd100001, 18'sd3001);
      push_sample_at(24'd100000, 18'sd3001);
      push_event(EV_DISARMED);
      push_event(EV_FORCE_START);
      push_event(EV_LIFTOFF);
      push_tick();
      push_sample_at(24'hFFFFFF, 18'sd3001);
      push_sample_at(24'd100001, 18'sh1FFFF);
      push_event(EV_APOGEE);
      repeat (4) push_sample_at(24'd123456, 18'sd3001);
      push_sample_at(24'd100001, 18'sd3000);
      push_sample_at(24'd100001, 18'sh20000);
      push_event(EV_LIFTOFF);
      push_item(OP_NONE, EV_UNUSED, 24'hFFFFFF, 18'sh20000);
      push_event(EV_FORCE_STOP);
      wait_idle();

      set_thresholds(24'd5000, 18'sd0, 16'd3, 24'd4);
      run_flights(70, 63, 0);
      set_thresholds(24'd0, 18'sh20000, 16'd0, 24'd1);
      run_flights(70, 0, 63);
      set_thresholds(24'hFFFFFF, 18'sh1FFFF, 16'hFFFF, 24'hFFFFFF);
      run_flights(70, 27, 27);
      set_thresholds(24'($urandom_range(0, 200000)), 18'($urandom_range(0, 131071) - 131072),
                     16'd2, 24'd0);
      run_flights(70, 0, 0);

      // build a long vote streak while unpowered, then raise the limit past it
      set_thresholds(24'd0, 18'sh20000, 16'd8, 24'd1);
      push_event(EV_ARMED);
      push_event(EV_LIFTOFF);
      push_event(EV_APOGEE);
      repeat (12)
         push_sample_at(24'($urandom_range(1, 24'hFFFFFF)),
                        18'(131071 - int'($urandom_range(0, 262142))));
      wait_idle();
      write_reg(CSR_SHUTDOWN_SAMPLES, 24'hFFFF);
      repeat (5) push_sample_at(24'hFFFFFF, 18'sh1FFFF);
      push_event(EV_FORCE_STOP);
      wait_idle();

      // last phase lands, then nothing may leave end
      set_thresholds(24'($urandom_range(0, 200000)), 18'($urandom_range(0, 5000)), 16'd1, 24'd3);
      run_flights(70, 27, 27);
      add_flight(1'b1);
      push_event(EV_FORCE_STOP);
      push_event(EV_FORCE_START);
      push_event(EV_ARMED);
      push_event(EV_LIFTOFF);
      push_event(EV_UNUSED);
      push_tick();
      push_sample_at(24'hFFFFFF, 18'sh1FFFF);
      push_item(OP_NONE, EV_LANDING, 24'd0, 18'sd0);
      wait_idle();

      repeat (4) @(negedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
